FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Command and status codes, the result record passed to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_READ   = 3'd2;
	localparam logic [2:0] CMD_SEARCH = 3'd3;
	localparam logic [2:0] CMD_SIZE   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [8:0] IDX_NONE = 9'h1FF;  // -1 in nine bits

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_out;
		logic [8:0]  found_index;
		logic [8:0]  element_count;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered. No reset of contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: command sequencer around the list RAM
// Shifts entries up or down one per cycle, or scans them with one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl import ple_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire logic [2:0]                    command,
	input  wire logic [8:0]                    position,
	input  wire logic [31:0]                   data_in,
	input  wire logic                          out_free,
	output logic                               push,
	output res_t                               res,
	output logic [$clog2(CAPACITY+1)-1:0]      count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;
	typedef enum logic [1:0] {M_UP, M_DOWN, M_SRCH} mode_t;

	state_t         state_q;
	mode_t          mode_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  rem_q;
	logic [CW-1:0]  rd_ptr_q;
	logic [CW-1:0]  idx_q;
	logic [AW-1:0]  pend_addr_q;
	logic           pend_q;
	logic           first_q;
	logic           rm_q;
	logic [31:0]    val_q;
	logic [1:0]     status_q;
	logic [31:0]    dout_q;
	logic [8:0]     fidx_q;

	logic [CW-1:0]  idx_c;
	logic [CW-1:0]  idxc_c;
	logic           issue_c;
	logic           done_c;
	logic           hit_c;
	logic           we_c;
	logic [AW-1:0]  waddr_c;
	logic [31:0]    wdata_c;
	logic [31:0]    rdata;

	// negative position, or at/past the end, resolves to the end
	always_comb begin
		if (position[8] || (32'(position[7:0]) >= 32'(count_q))) begin
			idx_c = count_q;
		end else begin
			idx_c = CW'(position[7:0]);
		end
		idxc_c = (idx_c == count_q) ? count_q - CW'(1) : idx_c;
	end

	assign issue_c = (state_q == RUN) && (rem_q != '0);
	assign done_c  = (state_q == RUN) && (rem_q == '0) && !pend_q;
	assign hit_c   = (state_q == RUN) && pend_q && (mode_q == M_SRCH) && (rdata == val_q);

	always_comb begin
		we_c    = 1'b0;
		waddr_c = pend_addr_q + AW'(1);
		wdata_c = rdata;
		if (done_c && mode_q == M_UP) begin
			we_c    = 1'b1;
			waddr_c = idx_q[AW-1:0];
			wdata_c = val_q;
		end else if (state_q == RUN && pend_q && mode_q == M_UP) begin
			we_c = 1'b1;
		end else if (state_q == RUN && pend_q && mode_q == M_DOWN && !first_q) begin
			we_c    = 1'b1;
			waddr_c = pend_addr_q - AW'(1);
		end
	end

	ple_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			mode_q      <= M_SRCH;
			count_q     <= '0;
			rem_q       <= '0;
			pend_q      <= 1'b0;
			first_q     <= 1'b0;
			rm_q        <= 1'b0;
			rd_ptr_q    <= '0;
			idx_q       <= '0;
			pend_addr_q <= '0;
			val_q       <= '0;
			status_q    <= ST_OK;
			dout_q      <= '0;
			fidx_q      <= IDX_NONE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd_valid) begin
						val_q    <= data_in;
						status_q <= ST_OK;
						dout_q   <= '0;
						fidx_q   <= IDX_NONE;
						pend_q   <= 1'b0;
						first_q  <= 1'b1;
						rm_q     <= (command == CMD_REMOVE);
						state_q  <= RUN;
						case (command)
							CMD_INSERT: begin
								mode_q   <= M_UP;
								idx_q    <= idx_c;
								rem_q    <= count_q - idx_c;
								rd_ptr_q <= count_q - CW'(1);
								if (32'(count_q) >= CAPACITY) begin
									status_q <= ST_FULL;
									state_q  <= FIN;
								end
							end
							CMD_REMOVE, CMD_READ: begin
								mode_q   <= M_DOWN;
								rd_ptr_q <= idxc_c;
								rem_q    <= (command == CMD_READ) ? CW'(1) : count_q - idxc_c;
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= FIN;
								end
							end
							CMD_SEARCH: begin
								mode_q   <= M_SRCH;
								rd_ptr_q <= '0;
								rem_q    <= count_q;
							end
							default: begin
								state_q <= FIN;  // size and unused codes
							end
						endcase
					end
				end
				RUN: begin
					pend_q      <= issue_c;
					pend_addr_q <= rd_ptr_q[AW-1:0];
					if (issue_c) begin
						rem_q    <= rem_q - CW'(1);
						rd_ptr_q <= (mode_q == M_UP) ? rd_ptr_q - CW'(1) : rd_ptr_q + CW'(1);
					end
					if (pend_q && mode_q == M_DOWN && first_q) begin
						dout_q  <= rdata;
						first_q <= 1'b0;
					end
					if (hit_c) begin
						fidx_q  <= 9'(pend_addr_q);
						pend_q  <= 1'b0;
						state_q <= FIN;
					end
					if (done_c) begin
						state_q <= FIN;
						case (mode_q)
							M_UP:    count_q <= count_q + CW'(1);
							M_DOWN:  count_q <= rm_q ? count_q - CW'(1) : count_q;
							default: status_q <= ST_NOT_FOUND;
						endcase
					end
				end
				FIN: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == IDLE);
	assign push      = (state_q == FIN) && out_free;
	assign count     = count_q;

	always_comb begin
		res.status        = status_q;
		res.data_out      = dout_q;
		res.found_index   = fidx_q;
		res.element_count = 9'(count_q);
	end

endmodule

`default_nettype wire

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Insert, remove, read, search and size commands on a RAM-backed list.
// ----------------------------------------------------------------------------
// Size commands and the full and empty cases skip the RAM; insert moves the
//   entries from the position to the end up, remove moves those after it down;
//   read fetches one entry; search stops at the first hit, or at the end on a miss.
// Throughput: one command at a time, the pace set by the single RAM port
//   moving or comparing one entry per cycle.
// Reset: arst_n clears the count and handshake state; list contents are
//   undefined until written and need no clearing pass.
`default_nettype none

module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // command[2:0], position[11:3], data_in[43:12]
	// result beat
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata    // status[1:0], data_out[33:2],
	                                    // found_index[42:34], element_count[51:43]
);

	res_t                             res;
	res_t                             out_q;
	logic                             m_tvalid_q;
	logic                             push;
	logic                             out_free;
	logic [$clog2(CAPACITY+1)-1:0]    count;

	// output register frees when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.command   (s_tdata[2:0]),
		.position  (s_tdata[11:3]),
		.data_in   (s_tdata[43:12]),
		.out_free  (out_free),
		.push      (push),
		.res       (res),
		.count     (count)
	);

	// result holding register; the sequencer may start the next command
	// while this beat waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, out_q.element_count, out_q.found_index,
	                   out_q.data_out, out_q.status};

	// list never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count) <= CAPACITY)
		else $error("list count above capacity");

	// a command is worked on alone: ready drops after each accepted beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second command accepted while busy");

	// a result never overwrites a beat that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// a full status is only given when the list holds CAPACITY entries
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.status == ST_FULL) |-> (32'(count) == CAPACITY))
		else $error("full status on a list with room");

endmodule

`default_nettype wire
